/* sv/strs_pkg.sv */
`timescale 1ns / 1ps
// Package for the sorted table range search block.
// Holds shared widths, codes, the controller state type and the command/status structs.
// Depends on nothing.
package strs_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 11;
    localparam int SLOT_W = 10;

    typedef logic [IDX_W-1:0] idx_t;

    // Index value that marks "no hit" (reads as -1 on the signed ports).
    localparam idx_t NO_HIT = '1;

    // Operation codes carried by the func field of a request.
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start;
        logic read;
        logic update;
        logic publish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
        logic out_free;
    } dp_status_t;

endpackage

/* sv/strs_if.sv */
`timescale 1ns / 1ps
// Handshake interfaces for the request and response channels.
// Depends on nothing.
interface search_req_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [9:0]         slot_index;
    logic signed [31:0] element_value;
    logic signed [31:0] search_key;

    modport source (output valid, output func, output slot_index, output element_value,
                    output search_key, input ready);
    modport sink   (input valid, input func, input slot_index, input element_value,
                    input search_key, output ready);
endinterface

interface search_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [10:0] first_index;
    logic signed [10:0] last_index;

    modport source (output valid, output found, output first_index, output last_index,
                    input ready);
    modport sink   (input valid, input found, input first_index, input last_index,
                    output ready);
endinterface

/* sv/strs_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine for the sorted table range search.
// Depends on strs_pkg (state type, command and status structs).
module strs_ctrl
    import strs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_func,
    output logic       in_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (in_func == FUNC_QUERY))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // Once both ranges close, the answer is ready.
                if (status.busy)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                state_next = S_READ;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.load  = in_valid && (in_func == FUNC_LOAD);
                cmd.start = in_valid && (in_func == FUNC_QUERY);
            end
            S_READ:
            begin
                cmd.read = status.busy;
            end
            S_CMP:
            begin
                cmd.update = 1'b1;
            end
            S_DONE:
            begin
                cmd.publish = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/strs_datapath.sv */
`timescale 1ns / 1ps
// Datapath: value memory, entry count register, two bisection units and result register.
// Depends on strs_pkg (widths, command and status structs).
module strs_datapath
    import strs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic                     cfg_wr_en,
    input  logic [IDX_W-1:0]         cfg_wr_data,
    input  logic [SLOT_W-1:0]        in_slot,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic signed [DATA_W-1:0] in_key,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic                     out_found,
    output logic signed [IDX_W-1:0]  out_first,
    output logic signed [IDX_W-1:0]  out_last
);

    localparam int         ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [16:0] DEPTH_L = 17'(TABLE_DEPTH);

    logic signed [DATA_W-1:0] value_mem [TABLE_DEPTH];

    logic [IDX_W-1:0]         entry_count_reg;
    logic [IDX_W-1:0]         count_eff;
    logic signed [DATA_W-1:0] key_reg;

    // Each bisection keeps the half-open range [lo, hix).
    idx_t lo_f_reg, lo_f_next, hix_f_reg, hix_f_next, hit_f_reg, hit_f_next;
    idx_t lo_l_reg, lo_l_next, hix_l_reg, hix_l_next, hit_l_reg, hit_l_next;
    logic signed [DATA_W-1:0] rd_f_reg, rd_l_reg;

    logic [IDX_W:0]    sum_f, sum_l;
    idx_t              mid_f, mid_l;
    logic [ADDR_W-1:0] addr_f, addr_l, wr_addr;
    logic              active_f, active_l, slot_ok;

    logic out_valid_reg, out_valid_next;
    logic out_found_reg;
    idx_t out_first_reg, out_last_reg;

    // Entry count register, written from the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    // A count beyond the table depth is clamped to the depth.
    assign count_eff = ({6'd0, entry_count_reg} > DEPTH_L) ? IDX_W'(DEPTH_L) : entry_count_reg;

    // Probe addresses: floor((lo + hix - 1) / 2), valid while the range is open.
    assign active_f = lo_f_reg < hix_f_reg;
    assign active_l = lo_l_reg < hix_l_reg;
    assign sum_f    = {1'b0, lo_f_reg} + {1'b0, hix_f_reg} - (IDX_W+1)'(1);
    assign sum_l    = {1'b0, lo_l_reg} + {1'b0, hix_l_reg} - (IDX_W+1)'(1);
    assign mid_f    = sum_f[IDX_W:1];
    assign mid_l    = sum_l[IDX_W:1];
    assign addr_f   = ADDR_W'(mid_f);
    assign addr_l   = ADDR_W'(mid_l);
    assign slot_ok  = {7'd0, in_slot} < DEPTH_L;
    assign wr_addr  = ADDR_W'(in_slot);

    // Value memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.load && slot_ok)
        begin
            value_mem[wr_addr] <= in_value;
        end
        if (cmd.read && active_f)
        begin
            rd_f_reg <= value_mem[addr_f];
        end
        if (cmd.read && active_l)
        begin
            rd_l_reg <= value_mem[addr_l];
        end
    end

    // Bisection updates. The first search narrows left after a hit, the last one right.
    always_comb
    begin
        lo_f_next  = lo_f_reg;
        hix_f_next = hix_f_reg;
        hit_f_next = hit_f_reg;
        lo_l_next  = lo_l_reg;
        hix_l_next = hix_l_reg;
        hit_l_next = hit_l_reg;
        if (cmd.start)
        begin
            lo_f_next  = '0;
            hix_f_next = count_eff;
            hit_f_next = NO_HIT;
            lo_l_next  = '0;
            hix_l_next = count_eff;
            hit_l_next = NO_HIT;
        end
        else if (cmd.update)
        begin
            if (active_f)
            begin
                if (key_reg == rd_f_reg)
                begin
                    hit_f_next = mid_f;
                    hix_f_next = mid_f;
                end
                else if (key_reg > rd_f_reg)
                begin
                    lo_f_next = mid_f + IDX_W'(1);
                end
                else
                begin
                    hix_f_next = mid_f;
                end
            end
            if (active_l)
            begin
                if (key_reg == rd_l_reg)
                begin
                    hit_l_next = mid_l;
                    lo_l_next  = mid_l + IDX_W'(1);
                end
                else if (key_reg > rd_l_reg)
                begin
                    lo_l_next = mid_l + IDX_W'(1);
                end
                else
                begin
                    hix_l_next = mid_l;
                end
            end
        end
    end

    // Search range, hit and key registers.
    always_ff @(posedge clk)
    begin
        lo_f_reg  <= lo_f_next;
        hix_f_reg <= hix_f_next;
        hit_f_reg <= hit_f_next;
        lo_l_reg  <= lo_l_next;
        hix_l_reg <= hix_l_next;
        hit_l_reg <= hit_l_next;
        if (cmd.start)
        begin
            key_reg <= in_key;
        end
    end

    // Result register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, captured when the controller publishes.
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_found_reg <= (hit_f_reg != NO_HIT);
            out_first_reg <= hit_f_reg;
            out_last_reg  <= hit_l_reg;
        end
    end

    assign status.busy     = active_f || active_l;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_first = out_first_reg;
    assign out_last  = out_last_reg;

endmodule

/* sv/sorted_table_range_search.sv */
`timescale 1ns / 1ps
// Top level of the sorted table range search: controller plus datapath.
// Depends on strs_pkg, strs_if (search_req_if, search_rsp_if), strs_ctrl and strs_datapath.
//
//  Port     Dir   Kind          Carries
//  req      in    valid/ready   func, slot_index, element_value, search_key
//  rsp      out   valid/ready   found, first_index, last_index
//  cfg_wr_* in    write strobe  entry_count
//
// A load writes its slot when the request is accepted. A query runs one memory read and one
// compare per probe; both bisections probe together on the two memory read ports.
// Reset clears the controller, the entry count and the result valid flag; the table is not
// cleared. A stalled response holds in the result register; a new request is taken once the
// previous result has moved into it.
module sorted_table_range_search
    import strs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_wr_data,
    search_req_if.sink        req,
    search_rsp_if.source      rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer for loads and the probe loop.
    strs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_func  (req.func),
        .in_ready (req.ready),
        .cmd      (cmd),
        .status   (status)
    );

    // Table, bisection registers and result register.
    strs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_slot     (req.slot_index),
        .in_value    (req.element_value),
        .in_key      (req.search_key),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .out_found   (rsp.found),
        .out_first   (rsp.first_index),
        .out_last    (rsp.last_index)
    );

endmodule

/* sv/strs_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for sorted_table_range_search and the bind that attaches it.
// Depends on strs_pkg (func codes) and the top level's channel ports.
module strs_checker
    import strs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              req_func,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              rsp_found,
    input logic signed [10:0] rsp_first_index,
    input logic signed [10:0] rsp_last_index
);

    // A pending response stays offered, with the same payload, until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable({rsp_found, rsp_first_index, rsp_last_index}))
        else $error("response dropped or changed before it was taken");

    // An absent key reports -1 for the first index.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> rsp_first_index == -11'sd1)
        else $error("absent key with a first index other than -1");

    // A found key reports a real slot for the first index.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |-> rsp_first_index >= 11'sd0)
        else $error("found key with a negative first index");

    // An accepted query occupies the block for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_func == FUNC_QUERY) |=> !req_ready)
        else $error("request taken while a query is still running");

    // A fresh response never follows a request accepted in the cycle just before.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_valid && req_ready))
        else $error("response appeared too soon after a request");

endmodule

bind sorted_table_range_search strs_checker u_strs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_func        (req.func),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_found       (rsp.found),
    .rsp_first_index (rsp.first_index),
    .rsp_last_index  (rsp.last_index)
);

/* test/sorted_table_range_search_check.sv */
`timescale 1ns / 1ps
// Checker for the sorted table range search: watches the request, response and config ports,
// predicts each query answer from its own copy of the table and compares it with the block.
// Depends on strs_pkg and the interfaces in strs_if.
module sorted_table_range_search_check
    import strs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_wr_data,
    search_req_if            req,
    search_rsp_if            rsp,
    output int               failures,
    output int               open_answers
);

    // One predicted answer to a search query.
    typedef struct packed {
        logic found;
        idx_t first;
        idx_t last;
    } search_answer_t;

    logic signed [DATA_W-1:0] value_table [TABLE_DEPTH];
    logic [IDX_W-1:0]         entry_count;
    search_answer_t           answers_due [$];
    search_answer_t           want;
    int                       span;

    // Bisection over slots 0 .. n-1. After a hit it keeps narrowing toward the high end
    // when toward_high is set, and toward the low end otherwise.
    function automatic idx_t bisect_slots(input int n, input logic signed [DATA_W-1:0] key,
                                          input bit toward_high);
        int lo;
        int hi;
        int mid;
        int hit;
        lo  = 0;
        hi  = n - 1;
        hit = -1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (key == value_table[mid])
            begin
                hit = mid;
                if (toward_high)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            else if (key > value_table[mid])
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return hit[IDX_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failures    = 0;
            entry_count = '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                value_table[i] = '0;
            answers_due.delete();
            open_answers <= 0;
        end
        else
        begin
            // Compare each accepted response with the oldest predicted answer.
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    failures = failures + 1;
                    $display("%0t ns: stray response, expected none, got %0d %0d %0d",
                             $time, rsp.found, rsp.first_index, rsp.last_index);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        failures = failures + 1;
                        $display("%0t ns: found mismatch, expected %0d, got %0d",
                                 $time, want.found, rsp.found);
                    end
                    if (rsp.first_index !== want.first)
                    begin
                        failures = failures + 1;
                        $display("%0t ns: first_index mismatch, expected %0d, got %0d",
                                 $time, $signed(want.first), rsp.first_index);
                    end
                    if (rsp.last_index !== want.last)
                    begin
                        failures = failures + 1;
                        $display("%0t ns: last_index mismatch, expected %0d, got %0d",
                                 $time, $signed(want.last), rsp.last_index);
                    end
                end
            end

            // A load updates the table; a query predicts one answer.
            if (req.valid && req.ready)
            begin
                if (req.func == FUNC_LOAD)
                    value_table[req.slot_index] = req.element_value;
                else
                begin
                    // Counts past the table depth saturate.
                    span = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
                    want.first = bisect_slots(span, req.search_key, 1'b0);
                    want.last  = bisect_slots(span, req.search_key, 1'b1);
                    want.found = (want.first != NO_HIT);
                    answers_due.push_back(want);
                end
            end

            if (cfg_wr_en)
                entry_count = cfg_wr_data;

            open_answers <= answers_due.size();
        end
    end

endmodule

/* test/sorted_table_range_search_test.sv */
`timescale 1ns / 1ps
// Testbench top for the sorted table range search: clock, reset, request stimulus,
// response stalls and the final verdict. Depends on strs_pkg, strs_if, the block and
// sorted_table_range_search_check.
module sorted_table_range_search_test
    import strs_pkg::*;
();

    localparam int TABLE_DEPTH   = 1024;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 400000;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_wr_data;
    int               failures;
    int               open_answers;
    int               cycle_count = 0;

    // Stimulus bookkeeping: what was loaded, and how many slots are searched.
    logic signed [DATA_W-1:0] slot_shadow [TABLE_DEPTH];
    int unsigned              active_count;
    int                       requests_sent;
    int                       burst_left;

    rx_mode_t rx_mode  = RX_OPEN;
    int       rx_left  = 0;
    int       rx_phase = 0;

    search_req_if req_ch ();
    search_rsp_if rsp_ch ();

    sorted_table_range_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    sorted_table_range_search_check #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .failures     (failures),
        .open_answers (open_answers)
    );

    always #4 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver stalls: a new pattern every so often, including stretches with no stall.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 160);
        end
        else
            rx_left <= rx_left - 1;
        rx_phase <= (rx_phase == 4) ? 0 : rx_phase + 1;
        case (rx_mode)
            RX_OPEN:     rsp_ch.ready <= 1'b1;
            RX_COIN:     rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_ch.ready <= (rx_phase < 2);
        endcase
    end

    // Present one request and hold it until accepted; bursts with random gaps between them.
    task automatic send_request(input func_t op, input logic [SLOT_W-1:0] slot,
                                input logic signed [DATA_W-1:0] value,
                                input logic signed [DATA_W-1:0] key);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 3);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        req_ch.valid         <= 1'b1;
        req_ch.func          <= op;
        req_ch.slot_index    <= slot;
        req_ch.element_value <= value;
        req_ch.search_key    <= key;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        requests_sent = requests_sent + 1;
    endtask

    task automatic load_slot(input int slot, input logic signed [DATA_W-1:0] value);
        slot_shadow[slot] = value;
        send_request(FUNC_LOAD, slot[SLOT_W-1:0], value, $urandom);
    endtask

    task automatic run_query(input logic signed [DATA_W-1:0] key);
        send_request(FUNC_QUERY, SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom, key);
    endtask

    // Stop sending and wait until every answer is back and the block has gone quiet.
    task automatic drain_answers();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (open_answers != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_entry_count(input logic [IDX_W-1:0] count);
        drain_answers();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        active_count = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    endtask

    // Load slots 0 .. n-1, ascending with runs of duplicates, or scrambled when not ordered.
    // Now and then a stray load lands past the used range.
    task automatic fill_table(input int n, input bit ordered, input int unsigned step,
                              input longint start);
        longint v;
        int     r;
        v = start;
        for (int i = 0; i < n; i++)
        begin
            if (!ordered)
            begin
                r = $urandom;
                v = r;
            end
            else if (i > 0 && $urandom_range(0, 3) != 0)
                v = v + $urandom_range(1, step);
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            load_slot(i, v[DATA_W-1:0]);
            if (n < TABLE_DEPTH && $urandom_range(0, 9) == 0)
                load_slot($urandom_range(n, TABLE_DEPTH - 1), $urandom);
        end
    endtask

    // Search keys: mostly present in the used range, some near misses, extremes and noise.
    function automatic logic signed [DATA_W-1:0] pick_key();
        int          r;
        int unsigned s;
        r = $urandom_range(0, 99);
        if (active_count == 0 || r >= 85)
            return $urandom;
        s = $urandom_range(0, active_count - 1);
        if (r < 60)
            return slot_shadow[s];
        if (r < 75)
            return slot_shadow[s] + (($urandom_range(0, 1) == 1) ? 1 : -1);
        return ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000;
    endfunction

    initial
    begin
        int     random_start;
        int     r;
        int     n;
        int     start_val;
        longint start;
        int unsigned step;

        rst_n       = 1'b0;
        burst_left  = 0;
        requests_sent = 0;
        active_count  = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            slot_shadow[i] = '0;
        req_ch.valid         <= 1'b0;
        req_ch.func          <= FUNC_LOAD;
        req_ch.slot_index    <= '0;
        req_ch.element_value <= '0;
        req_ch.search_key    <= '0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero count after reset answers absent without touching the table.
        run_query(32'sh80000000);
        run_query(32'sh7fffffff);

        // Directed: small table with duplicated extremes at both ends.
        load_slot(0, 32'sh80000000);
        load_slot(1, 32'sh80000000);
        load_slot(2, -7);
        load_slot(3, 32'sh7fffffff);
        load_slot(4, 32'sh7fffffff);
        load_slot(TABLE_DEPTH - 1, 32'sh5a5a5a5a);
        set_entry_count(5);
        run_query(32'sh80000000);
        run_query(-7);
        run_query(32'sh7fffffff);
        run_query(0);
        run_query(32'sh80000001);
        run_query(32'sh7ffffffe);
        run_query(-8);
        set_entry_count(1);
        run_query(32'sh80000000);
        run_query(-7);

        // Whole table ascending, then searched at full depth and with a saturating count.
        random_start = requests_sent;
        start_val = $urandom_range(0, 255);
        start = 64'sd0 - 64'sd2147483648 + start_val;
        fill_table(TABLE_DEPTH, 1'b1, 1 << 22, start);
        set_entry_count(IDX_W'(TABLE_DEPTH));
        repeat (40) run_query(pick_key());
        set_entry_count(11'h7ff);
        repeat (20) run_query(pick_key());

        // Random phases: mostly small freshly loaded tables with many queries.
        while (requests_sent - random_start < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                set_entry_count(0);
                repeat (3) run_query(pick_key());
            end
            else if (r < 18)
            begin
                case ($urandom_range(0, 2))
                    0:       set_entry_count(IDX_W'(TABLE_DEPTH));
                    1:       set_entry_count(IDX_W'($urandom_range(TABLE_DEPTH + 1, 2047)));
                    default: set_entry_count(IDX_W'($urandom_range(41, TABLE_DEPTH - 1)));
                endcase
                repeat ($urandom_range(10, 25)) run_query(pick_key());
            end
            else
            begin
                n = $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0:       step = 1;
                    1:       step = 8;
                    2:       step = 100000;
                    default: step = 1 << 26;
                endcase
                start_val = $urandom;
                start = start_val;
                if ($urandom_range(0, 4) == 0)
                    start = 64'sd0 - 64'sd2147483648;
                fill_table(n, $urandom_range(0, 6) != 0, step, start);
                set_entry_count(IDX_W'(n));
                repeat ($urandom_range(n, 3 * n)) run_query(pick_key());
            end
        end

        drain_answers();
        if (failures == 0 && open_answers == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
sv/strs_pkg.sv
sv/strs_if.sv
sv/strs_ctrl.sv
sv/strs_datapath.sv
sv/sorted_table_range_search.sv
sv/strs_checker.sv
test/sorted_table_range_search_check.sv
test/sorted_table_range_search_test.sv
